// ===== rtl/dam_pkg.sv =====
package dam_pkg;

  // calendar and clock constants
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned LAST_HOUR     = 23;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned LAST_MONTH    = 12;
  localparam int unsigned LEN_LONG      = 31;
  localparam int unsigned LEN_SHORT     = 30;
  localparam int unsigned LEN_FEB       = 28;

  // month codes
  localparam logic [7:0] MON_JAN = 8'd1;
  localparam logic [7:0] MON_FEB = 8'd2;
  localparam logic [7:0] MON_MAR = 8'd3;
  localparam logic [7:0] MON_APR = 8'd4;
  localparam logic [7:0] MON_MAY = 8'd5;
  localparam logic [7:0] MON_JUN = 8'd6;
  localparam logic [7:0] MON_JUL = 8'd7;
  localparam logic [7:0] MON_AUG = 8'd8;
  localparam logic [7:0] MON_SEP = 8'd9;
  localparam logic [7:0] MON_OCT = 8'd10;
  localparam logic [7:0] MON_NOV = 8'd11;
  localparam logic [7:0] MON_DEC = 8'd12;

  // input transaction
  typedef struct packed {
    logic [7:0] year_in;
    logic [7:0] month_in;
    logic [4:0] day_in;
    logic [2:0] weekday_in;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
    logic [5:0] second_in;
    logic [7:0] minutes_to_add;
  } dam_in_t;

  // result transaction
  typedef struct packed {
    logic [7:0] year_out;
    logic [7:0] month_out;
    logic [7:0] day_out;
    logic [2:0] weekday_out;
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;
  } dam_out_t;

  // time part handed from the clock adder to the calendar stage
  typedef struct packed {
    logic       day_roll;
    logic [4:0] hour;
    logic [5:0] minute;
  } dam_time_t;

endpackage

// ===== rtl/dam_time_add.sv =====
module dam_time_add (
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [7:0]         add_i,
  output dam_pkg::dam_time_t time_o
);
  import dam_pkg::*;

  logic [2:0] add_hrs;
  logic [5:0] add_min;
  logic [6:0] msum;
  logic       mcarry;
  logic [5:0] hsum;

  // split the count into whole hours and leftover minutes by compares
  always_comb begin
    if (add_i >= 8'(4 * MINS_PER_HOUR)) begin
      add_hrs = 3'd4;
      add_min = 6'(add_i - 8'(4 * MINS_PER_HOUR));
    end else if (add_i >= 8'(3 * MINS_PER_HOUR)) begin
      add_hrs = 3'd3;
      add_min = 6'(add_i - 8'(3 * MINS_PER_HOUR));
    end else if (add_i >= 8'(2 * MINS_PER_HOUR)) begin
      add_hrs = 3'd2;
      add_min = 6'(add_i - 8'(2 * MINS_PER_HOUR));
    end else if (add_i >= 8'(MINS_PER_HOUR)) begin
      add_hrs = 3'd1;
      add_min = 6'(add_i - 8'(MINS_PER_HOUR));
    end else begin
      add_hrs = 3'd0;
      add_min = add_i[5:0];
    end
  end

  // minute sum with a single carry into the hour
  assign msum   = 7'(minute_i) + 7'(add_min);
  assign mcarry = (msum >= 7'(MINS_PER_HOUR));
  assign hsum   = 6'(hour_i) + 6'(add_hrs) + 6'(mcarry);

  // one day rollover at most
  always_comb begin
    time_o.minute   = mcarry ? 6'(msum - 7'(MINS_PER_HOUR)) : msum[5:0];
    time_o.day_roll = (hsum > 6'(LAST_HOUR));
    time_o.hour     = time_o.day_roll ? 5'(hsum - 6'(HOURS_PER_DAY)) : hsum[4:0];
  end

endmodule

// ===== rtl/dam_cal_roll.sv =====
module dam_cal_roll (
  input  logic       roll_i,
  input  logic [7:0] year_i,
  input  logic [7:0] month_i,
  input  logic [4:0] day_i,
  input  logic [2:0] weekday_i,
  output logic [7:0] year_o,
  output logic [7:0] month_o,
  output logic [7:0] day_o,
  output logic [2:0] weekday_o
);
  import dam_pkg::*;

  logic [4:0] mlen;
  logic       known;

  // month length, unknown months do not roll the date
  always_comb begin
    known = 1'b1;
    unique case (month_i)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC: mlen = 5'(LEN_LONG);
      MON_FEB:                   mlen = 5'(LEN_FEB);
      MON_APR, MON_JUN,
      MON_SEP, MON_NOV:          mlen = 5'(LEN_SHORT);
      default: begin
        mlen  = 5'd0;
        known = 1'b0;
      end
    endcase
  end

  // advance weekday, day, month and year on a rollover
  always_comb begin
    year_o    = year_i;
    month_o   = month_i;
    day_o     = 8'(day_i);
    weekday_o = weekday_i;
    if (roll_i) begin
      weekday_o = (weekday_i == 3'(DAYS_PER_WEEK)) ? 3'd1 : 3'(weekday_i + 3'd1);
      if (known) begin
        if (day_i == mlen) begin
          day_o = 8'd1;
          if (month_i == 8'(LAST_MONTH)) begin
            month_o = MON_JAN;
            year_o  = 8'(year_i + 8'd1);
          end else begin
            month_o = 8'(month_i + 8'd1);
          end
        end else begin
          day_o = 8'(day_i) + 8'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/date_add_minutes.sv =====
// date_add_minutes: date and time advanced by 0 to 255 minutes
// an accepted transaction passes the input register, then the result register, which drives out_valid
// throughput: one transaction per cycle, busy stays low, no stall path
// the result register feeds the output ports, the receiver cannot stall
// reset: synchronous active-low rst_n clears the valid flags only
module date_add_minutes (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dam_pkg::dam_in_t  in_item,
  output logic              out_valid,
  output dam_pkg::dam_out_t out_item
);
  import dam_pkg::*;

  dam_in_t   in_r;
  logic      in_valid_r;
  dam_out_t  out_r;
  dam_out_t  out_nxt;
  logic      out_valid_r;
  dam_time_t tm;

  // never blocks, a transaction can enter every cycle
  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    if (start && !busy) begin
      in_r <= in_item;
    end
  end

  // minute and hour addition
  dam_time_add u_time (
    .hour_i   (in_r.hour_in),
    .minute_i (in_r.minute_in),
    .add_i    (in_r.minutes_to_add),
    .time_o   (tm)
  );

  // calendar rollover
  dam_cal_roll u_cal (
    .roll_i    (tm.day_roll),
    .year_i    (in_r.year_in),
    .month_i   (in_r.month_in),
    .day_i     (in_r.day_in),
    .weekday_i (in_r.weekday_in),
    .year_o    (out_nxt.year_out),
    .month_o   (out_nxt.month_out),
    .day_o     (out_nxt.day_out),
    .weekday_o (out_nxt.weekday_out)
  );

  assign out_nxt.hour_out   = tm.hour;
  assign out_nxt.minute_out = tm.minute;
  assign out_nxt.second_out = in_r.second_in;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
    if (in_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  a_strobe_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("result strobe without an accepted transaction");

  a_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n, 2) |->
      out_item.second_out == $past(in_item.second_in, 2))
    else $error("second field not passed through");

  a_weekday_needs_roll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n, 2) &&
    (out_item.weekday_out != $past(in_item.weekday_in, 2)) |->
      out_item.hour_out < $past(in_item.hour_in, 2))
    else $error("weekday changed without an hour rollover");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

// ===== tb/tb_date_add_minutes.sv =====
`timescale 1ns / 1ps

module tb_date_add_minutes;
  import dam_pkg::*;

  // one directed row: stimulus plus an optional hand-written result
  typedef struct {
    dam_in_t  stim;
    bit       typed;
    dam_out_t want;
  } date_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  dam_in_t  in_item = '0;
  logic     out_valid;
  dam_out_t out_item;

  dam_out_t    pending_dates[$];
  date_row_t   date_table[$];
  int unsigned mismatches = 0;

  date_add_minutes dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // days in a month, zero for an unknown month
  function automatic int unsigned month_length(input logic [7:0] month);
    case (month)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: return LEN_LONG;
      MON_FEB: return LEN_FEB;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return LEN_SHORT;
      default: return 0;
    endcase
  endfunction

  // date and time moved forward by the minute count
  function automatic dam_out_t advance_date(input dam_in_t d);
    dam_out_t    r;
    int unsigned hsum;
    int unsigned msum;
    int unsigned mlen;
    hsum = 32'(d.hour_in) + 32'(d.minutes_to_add) / MINS_PER_HOUR;
    msum = 32'(d.minute_in) + 32'(d.minutes_to_add) % MINS_PER_HOUR;
    r.year_out    = d.year_in;
    r.month_out   = d.month_in;
    r.day_out     = {3'b000, d.day_in};
    r.weekday_out = d.weekday_in;
    r.second_out  = d.second_in;
    // single minute carry
    if (msum >= MINS_PER_HOUR) begin
      hsum++;
      msum -= MINS_PER_HOUR;
    end
    // at most one day of rollover
    if (hsum > LAST_HOUR) begin
      hsum -= HOURS_PER_DAY;
      r.weekday_out = (d.weekday_in == 3'(DAYS_PER_WEEK)) ? 3'd1 : d.weekday_in + 3'd1;
      mlen = month_length(d.month_in);
      if (mlen != 0) begin
        if (32'(d.day_in) == mlen) begin
          r.day_out = 8'd1;
          if (d.month_in == MON_DEC) begin
            r.month_out = MON_JAN;
            r.year_out  = d.year_in + 8'd1;
          end else begin
            r.month_out = d.month_in + 8'd1;
          end
        end else begin
          r.day_out = 8'(d.day_in) + 8'd1;
        end
      end
    end
    r.hour_out   = 5'(hsum);
    r.minute_out = 6'(msum);
    return r;
  endfunction

  function automatic dam_in_t mk_in(input logic [7:0] y, input logic [7:0] mo,
                                    input logic [4:0] d, input logic [2:0] w,
                                    input logic [4:0] h, input logic [5:0] mi,
                                    input logic [5:0] s, input logic [7:0] add);
    return '{y, mo, d, w, h, mi, s, add};
  endfunction

  function automatic dam_out_t mk_out(input logic [7:0] y, input logic [7:0] mo,
                                      input logic [7:0] d, input logic [2:0] w,
                                      input logic [4:0] h, input logic [5:0] mi,
                                      input logic [5:0] s);
    return '{y, mo, d, w, h, mi, s};
  endfunction

  // mostly valid dates biased toward day and month ends, some raw noise
  function automatic dam_in_t random_date();
    dam_in_t     d;
    logic [63:0] raw;
    int unsigned mlen;
    raw = {$urandom, $urandom};
    d = raw[$bits(dam_in_t)-1:0];
    if ($urandom_range(9) != 0) begin
      if ($urandom_range(19) != 0)
        d.month_in = 8'($urandom_range(12, 1));
      mlen = month_length(d.month_in);
      if (mlen == 0)
        mlen = LEN_LONG;
      case ($urandom_range(3))
        0: d.day_in = 5'(mlen);
        1: d.day_in = 5'(mlen - 1);
        default: d.day_in = 5'($urandom_range(mlen, 1));
      endcase
      d.weekday_in = 3'($urandom_range(7, 1));
      d.hour_in    = $urandom_range(1) ? 5'($urandom_range(23, 20)) : 5'($urandom_range(23));
      d.minute_in  = 6'($urandom_range(59));
      d.second_in  = 6'($urandom_range(59));
    end
    return d;
  endfunction

  // drive one transaction, optionally after an idle gap
  task automatic send_date(input dam_in_t item, input dam_out_t want, input int idle_pct);
    int unsigned gap;
    bit          ready;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(4, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do begin
      @(negedge clk);
      ready = !busy;
      @(posedge clk);
    end while (!ready);
    pending_dates.push_back(want);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    dam_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_dates.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_item);
      end else begin
        want = pending_dates.pop_front();
        check_field("year",    want.year_out,        out_item.year_out);
        check_field("month",   want.month_out,       out_item.month_out);
        check_field("day",     want.day_out,         out_item.day_out);
        check_field("weekday", 8'(want.weekday_out), 8'(out_item.weekday_out));
        check_field("hour",    8'(want.hour_out),    8'(out_item.hour_out));
        check_field("minute",  8'(want.minute_out),  8'(out_item.minute_out));
        check_field("second",  8'(want.second_out),  8'(out_item.second_out));
      end
    end
  end

  // stimulus
  initial begin
    dam_out_t    want;
    dam_in_t     d;
    int          idle_pct[3] = '{9, 48, 0};
    int unsigned waited;

    // directed rows, hand results only where obvious
    date_table.push_back('{mk_in(8'd0, 8'd0, 5'd0, 3'd0, 5'd0, 6'd0, 6'd0, 8'd0), 1'b1,
                           mk_out(8'd0, 8'd0, 8'd0, 3'd0, 5'd0, 6'd0, 6'd0)});
    date_table.push_back('{mk_in(8'd255, 8'd255, 5'd31, 3'd7, 5'd31, 6'd63, 6'd63, 8'd255),
                           1'b1, mk_out(8'd255, 8'd255, 8'd31, 3'd1, 5'd12, 6'd18, 6'd63)});
    date_table.push_back('{mk_in(8'd255, MON_DEC, 5'd31, 3'd7, 5'd23, 6'd59, 6'd30, 8'd1),
                           1'b1, mk_out(8'd0, MON_JAN, 8'd1, 3'd1, 5'd0, 6'd0, 6'd30)});
    // end of every month from January to November
    for (int m = 1; m <= 11; m++)
      date_table.push_back('{mk_in(8'd24, 8'(m), 5'(month_length(8'(m))), 3'd3, 5'd23,
                                   6'd30, 6'd15, 8'd45), 1'b0, '0});
    // day past the month length
    date_table.push_back('{mk_in(8'd23, MON_FEB, 5'd29, 3'd2, 5'd22, 6'd10, 6'd1, 8'd120),
                           1'b0, '0});
    date_table.push_back('{mk_in(8'd23, MON_APR, 5'd31, 3'd5, 5'd23, 6'd0, 6'd2, 8'd60),
                           1'b0, '0});
    // unknown months
    date_table.push_back('{mk_in(8'd10, 8'd0, 5'd31, 3'd6, 5'd23, 6'd59, 6'd3, 8'd1),
                           1'b0, '0});
    date_table.push_back('{mk_in(8'd10, 8'd13, 5'd30, 3'd1, 5'd21, 6'd0, 6'd4, 8'd200),
                           1'b0, '0});
    // weekday zero rolls to one
    date_table.push_back('{mk_in(8'd50, MON_MAR, 5'd5, 3'd0, 5'd23, 6'd50, 6'd5, 8'd10),
                           1'b0, '0});
    // minute carry without a day roll
    date_table.push_back('{mk_in(8'd7, MON_MAY, 5'd9, 3'd4, 5'd10, 6'd45, 6'd6, 8'd15),
                           1'b0, '0});
    // out of range minute and hour
    date_table.push_back('{mk_in(8'd7, MON_JUN, 5'd9, 3'd4, 5'd10, 6'd63, 6'd7, 8'd59),
                           1'b0, '0});
    date_table.push_back('{mk_in(8'd7, MON_JUL, 5'd9, 3'd4, 5'd31, 6'd0, 6'd8, 8'd0),
                           1'b0, '0});
    // largest count, and the last minute before a roll
    date_table.push_back('{mk_in(8'd99, MON_AUG, 5'd15, 3'd7, 5'd19, 6'd45, 6'd9, 8'd255),
                           1'b0, '0});
    date_table.push_back('{mk_in(8'd99, MON_SEP, 5'd15, 3'd7, 5'd23, 6'd0, 6'd59, 8'd59),
                           1'b0, '0});

    // reset
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (date_table[i]) begin
      want = date_table[i].typed ? date_table[i].want : advance_date(date_table[i].stim);
      send_date(date_table[i].stim, want, idle_pct[0]);
    end

    // random phases with sender gap chances of 9, 48 and 0 percent
    for (int p = 0; p < 3; p++) begin
      repeat (283) begin
        d = random_date();
        send_date(d, advance_date(d), idle_pct[p]);
      end
    end
    start <= 1'b0;

    // drain
    waited = 0;
    while (pending_dates.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);

    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (pending_dates.size() != 0)
        $display("%0t: %0d results missing, expected %p, got none", $time,
                 pending_dates.size(), pending_dates[0]);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dam_pkg.sv
rtl/dam_time_add.sv
rtl/dam_cal_roll.sv
rtl/date_add_minutes.sv
tb/tb_date_add_minutes.sv
